### rtl/core/svm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the sample voice mixer
// Holds the input and result payload structs, function codes and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam logic [1:0] FUNC_TRIGGER = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE  = 2'd2;
  localparam logic [1:0] FUNC_DESC    = 2'd3;

  localparam logic signed [16:0] SAT_MAX = 17'sd32767;
  localparam logic signed [16:0] SAT_MIN = -17'sd32768;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         sound_id;
    logic               restart;
    logic [15:0]        mem_addr;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [15:0]        sound_base;
    logic [16:0]        sound_frames;
  } svm_in_t;

  typedef struct packed {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
  } svm_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SERVE,
    OP_MIX_DESC,
    OP_MIX_RD,
    OP_MIX_ADD,
    OP_EMIT
  } svm_op_t;

  typedef struct packed {
    svm_op_t op;
  } svm_cmd_t;

  typedef struct packed {
    logic serve_last;
    logic mix_last;
  } svm_sts_t;

endpackage

### rtl/core/svm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ram: generic single-port RAM
// One write or one read per cycle, with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

### rtl/core/svm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ctrl: controller of the sample voice mixer
// Sequences a tick through trigger service, then a descriptor read, a
// sample read and an add step for every voice, then emission of the frame.
// ----------------------------------------------------------------------------
module svm_ctrl
  import svm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     is_tick,
  input  svm_sts_t sts,
  output logic     busy,
  output svm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CAPTURE, S_SERVE, S_DESC, S_RD, S_ADD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (start) begin
        state_nxt = is_tick ? S_CAPTURE : S_IDLE;
      end
      S_CAPTURE: begin
        state_nxt = S_SERVE;
      end
      S_SERVE:   if (sts.serve_last) begin
        state_nxt = S_DESC;
      end
      S_DESC:    state_nxt = S_RD;
      S_RD:      state_nxt = S_ADD;
      S_ADD:     state_nxt = sts.mix_last ? S_EMIT : S_DESC;
      S_EMIT:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    unique case (state_r)
      S_IDLE:    cmd.op = start ? OP_CAPTURE : OP_NONE;
      S_CAPTURE: cmd.op = OP_NONE;
      S_SERVE:   cmd.op = OP_SERVE;
      S_DESC:    cmd.op = OP_MIX_DESC;
      S_RD:      cmd.op = OP_MIX_RD;
      S_ADD:     cmd.op = OP_MIX_ADD;
      S_EMIT:    cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // A tick never skips trigger service.
  a_serve_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CAPTURE |=> state_r == S_SERVE)
    else $error("capture not followed by serve");
  // Every read step is followed by its add step.
  a_rd_add: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_ADD)
    else $error("read without add");
  // Emission returns to idle.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |=> state_r == S_IDLE)
    else $error("emit not followed by idle");

endmodule

### rtl/core/svm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dp: datapath of the sample voice mixer
// Holds the sound table, trigger latches, voice registers, sample memory
// and the saturating stereo accumulator.
// ----------------------------------------------------------------------------
module svm_dp
  import svm_pkg::*;
#(
  parameter int VOICES       = 32,
  parameter int SOUNDS       = 64,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  svm_in_t  in_data,
  input  svm_cmd_t cmd,
  output svm_sts_t sts,
  output logic     out_valid,
  output svm_out_t out_data
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int AW = $clog2(SAMPLE_DEPTH);

  logic [SOUNDS-1:0] pend_r, rst_fl_r, dvld_r;
  logic [VOICES-1:0] act_r;
  logic [5:0]    vsnd_r    [VOICES];
  logic [16:0]   vpos_r    [VOICES];

  logic [SW-1:0] sidx_r;
  logic [VW-1:0] vidx_r;
  logic signed [15:0] accl_r, accr_r;
  logic          out_valid_r;
  svm_out_t      out_r;

  // Sound lookup for the trigger sweep: a whole sound per cycle.
  logic              id_ok;
  logic [SW-1:0]     id_s;
  logic [VOICES-1:0] match, free;
  logic [VW-1:0]     match_i, free_i;
  logic              match_any, free_any;

  assign id_s  = SW'(in_data.sound_id);
  assign id_ok = ({26'd0, in_data.sound_id} < 32'(SOUNDS));

  always_comb begin
    match_i = '0;
    free_i  = '0;
    match_any = 1'b0;
    free_any  = 1'b0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      match[v] = act_r[v] && ({{(32-6){1'b0}}, vsnd_r[v]} == 32'(sidx_r));
      free[v]  = !act_r[v];
      if (match[v]) begin
        match_i = VW'(v);
        match_any = 1'b1;
      end
      if (free[v]) begin
        free_i = VW'(v);
        free_any = 1'b1;
      end
    end
  end

  // Current voice of the mix sweep. Its descriptor is read in the first
  // step, its sample frame in the second, and the add happens in the third.
  logic [SW-1:0] csnd;
  logic [15:0]   cbase;
  logic [16:0]   clen, cpos, cpos_inc;
  logic [AW-1:0] raddr;
  logic          cplay;
  logic          desc_we;
  logic [SW-1:0] desc_addr;
  logic [32:0]   desc_rdata;
  assign csnd     = SW'(vsnd_r[vidx_r]);
  assign cbase    = desc_rdata[32:17];
  assign clen     = dvld_r[csnd] ? desc_rdata[16:0] : 17'd0;
  assign cpos     = vpos_r[vidx_r];
  assign cplay    = act_r[vidx_r] && (clen != 17'd0) && (cpos < clen);
  assign cpos_inc = cpos + 17'd1;
  assign raddr    = AW'({1'b0, cbase} + {1'b0, cpos[15:0]});

  // Descriptor table: a never-written sound reads as length zero through its
  // valid bit. The address holds steady over a voice's three steps.
  assign desc_we   = (cmd.op == OP_CAPTURE) && (in_data.func == FUNC_DESC) && id_ok;
  assign desc_addr = desc_we ? id_s : csnd;

  svm_ram #(.WIDTH(33), .DEPTH(SOUNDS)) u_desc (
    .clk   (clk),
    .we    (desc_we),
    .addr  (desc_addr),
    .wdata ({in_data.sound_base, in_data.sound_frames}),
    .rdata (desc_rdata)
  );

  // Sample memory port: writes on sample transfers, reads in the mix sweep.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  assign ram_we   = start && !busy && (in_data.func == FUNC_SAMPLE);
  assign ram_addr = ram_we ? AW'(in_data.mem_addr) : raddr;

  svm_ram #(.WIDTH(32), .DEPTH(SAMPLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.sample_right, in_data.sample_left}),
    .rdata (ram_rdata)
  );

  logic signed [16:0] suml, sumr;
  logic signed [15:0] satl, satr;
  assign suml = 17'(accl_r) + 17'(signed'(ram_rdata[15:0]));
  assign sumr = 17'(accr_r) + 17'(signed'(ram_rdata[31:16]));
  assign satl = (suml > SAT_MAX) ? 16'sh7fff : (suml < SAT_MIN) ? -16'sh8000 : suml[15:0];
  assign satr = (sumr > SAT_MAX) ? 16'sh7fff : (sumr < SAT_MIN) ? -16'sh8000 : sumr[15:0];

  assign sts.serve_last = (32'(sidx_r) == 32'(SOUNDS - 1));
  assign sts.mix_last   = (32'(vidx_r) == 32'(VOICES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      rst_fl_r    <= '0;
      dvld_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        vsnd_r[v] <= '0;
        vpos_r[v] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_CAPTURE: begin
          sidx_r <= '0;
          if (in_data.func == FUNC_TRIGGER && id_ok && !pend_r[id_s]) begin
            pend_r[id_s]   <= 1'b1;
            rst_fl_r[id_s] <= in_data.restart;
          end
          if (desc_we) begin
            dvld_r[id_s] <= 1'b1;
          end
        end
        OP_SERVE: begin
          if (pend_r[sidx_r]) begin
            pend_r[sidx_r] <= 1'b0;
            if (match_any) begin
              if (rst_fl_r[sidx_r]) begin
                vpos_r[match_i] <= '0;
              end
            end else if (free_any) begin
              act_r[free_i]  <= 1'b1;
              vsnd_r[free_i] <= 6'(sidx_r);
              vpos_r[free_i] <= '0;
            end
          end
          sidx_r <= sidx_r + SW'(1);
          vidx_r <= '0;
          accl_r <= '0;
          accr_r <= '0;
        end
        OP_MIX_ADD: begin
          if (act_r[vidx_r]) begin
            if (cplay) begin
              accl_r <= satl;
              accr_r <= satr;
              vpos_r[vidx_r] <= cpos_inc;
              if (cpos_inc >= clen) begin
                act_r[vidx_r] <= 1'b0;
              end
            end else begin
              act_r[vidx_r] <= 1'b0;
            end
          end
          vidx_r <= vidx_r + VW'(1);
        end
        OP_EMIT: begin
          out_valid_r <= 1'b1;
          out_r       <= '{mix_left: accl_r, mix_right: accr_r};
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result strobe lasts one cycle.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held");
  // Sample writes only happen while idle.
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !busy)
    else $error("sample write while busy");
  // Trigger latches are all clear after a tick.
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> pend_r == '0)
    else $error("trigger left pending");

endmodule

### rtl/core/sample_voice_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer_unit: polyphonic sample-playback voice mixer
// Plays stored stereo sounds on a set of voices and mixes one frame per tick.
// ----------------------------------------------------------------------------
// Usage. An input transfer happens when start is high and busy is low. The
// item's func field selects a trigger, a frame tick, a sample write or a
// sound descriptor write. Sample writes, triggers and descriptor writes all
// take effect at the transfer edge itself; busy stays low, so another item
// can be transferred in the very next cycle.
// A frame tick raises busy through a capture step, a serve step for each
// sound to serve latched triggers, then a descriptor read, a sample read
// and an add step for every voice, because the sound descriptor and the
// sample frame each come from a RAM with registered read data, and an
// emit step.
// The mixed frame appears on out_data for exactly one cycle with out_valid
// high, in the first cycle after busy falls; the next item can be
// transferred in that same cycle. The frame is transferred on that cycle
// and cannot be held off.
// Reset clears the sound table, trigger latches and all voices; the sample
// memory is not cleared and must be written before it is played.
// ----------------------------------------------------------------------------
module sample_voice_mixer_unit
  import svm_pkg::*;
#(
  parameter int VOICES       = 32,
  parameter int SOUNDS       = 64,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  svm_in_t  in_data,
  output logic     out_valid,
  output svm_out_t out_data
);

  svm_cmd_t cmd;
  svm_sts_t sts;
  logic     busy_w;

  // The controller sees every transfer that is not a sample write, and whether it starts a tick.
  svm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start && (in_data.func != FUNC_SAMPLE)),
    .is_tick (in_data.func == FUNC_TICK),
    .sts     (sts),
    .busy    (busy_w),
    .cmd     (cmd)
  );

  // The datapath holds all state but the controller's sequence state and does the arithmetic.
  svm_dp #(
    .VOICES       (VOICES),
    .SOUNDS       (SOUNDS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy_w),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = busy_w;

endmodule

### sim/sample_voice_mixer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_mixer_unit_tb: self-checking bench for the voice mixer
// Loads sample frames and sound descriptors, then fires triggers and frame
// ticks. A behavioral mixer kept in the bench predicts every mixed frame,
// and a monitor checks each frame against the oldest prediction.
// ----------------------------------------------------------------------------
module sample_voice_mixer_unit_tb;
  import svm_pkg::*;

  localparam int NUM_VOICES  = 32;
  localparam int NUM_SOUNDS  = 64;
  localparam int MEM_DEPTH   = 65536;
  localparam int WDOG_LIMIT  = 20000;
  // Sample memory is only ever read inside this window. Every address in it
  // is written before the first tick, so no voice reads an unwritten frame.
  localparam int WIN_BASE    = 16'hFF00;
  localparam int WIN_SIZE    = 512;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  svm_in_t  in_data;
  logic     out_valid;
  svm_out_t out_data;

  sample_voice_mixer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Predictor state, mirrors the block's architectural state.
  logic [31:0] pred_mem [MEM_DEPTH];
  logic [15:0] pred_base [NUM_SOUNDS];
  logic [16:0] pred_len [NUM_SOUNDS];
  logic        pred_pend [NUM_SOUNDS];
  logic        pred_rst [NUM_SOUNDS];
  logic        pred_act [NUM_VOICES];
  logic [5:0]  pred_snd [NUM_VOICES];
  logic [16:0] pred_pos [NUM_VOICES];

  svm_in_t  cmd_queue[$];
  svm_out_t mix_queue[$];
  int       mismatches = 0;
  int       wdog = 0;
  bit       stim_done;
  int       gap_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Applies one accepted command to the predictor; a tick pushes its frame.
  function automatic void apply_command(svm_in_t c);
    int l, r, snd;
    logic [15:0] a;
    bit hit;
    l = 0;
    r = 0;
    case (c.func)
      FUNC_TRIGGER: begin
        if (!pred_pend[c.sound_id]) begin
          pred_pend[c.sound_id] = 1'b1;
          pred_rst[c.sound_id]  = c.restart;
        end
      end
      FUNC_SAMPLE: pred_mem[c.mem_addr] = {c.sample_right, c.sample_left};
      FUNC_DESC: begin
        pred_base[c.sound_id] = c.sound_base;
        pred_len[c.sound_id]  = c.sound_frames;
      end
      default: begin
        // Serve latched triggers in sound order before mixing.
        for (int s = 0; s < NUM_SOUNDS; s++) begin
          if (pred_pend[s]) begin
            hit = 1'b0;
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (!hit && pred_act[v] && pred_snd[v] == s) begin
                hit = 1'b1;
                if (pred_rst[s]) pred_pos[v] = '0;
              end
            end
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (!hit && !pred_act[v]) begin
                hit = 1'b1;
                pred_act[v] = 1'b1;
                pred_snd[v] = s[5:0];
                pred_pos[v] = '0;
              end
            end
            pred_pend[s] = 1'b0;
          end
        end
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (pred_act[v]) begin
            snd = pred_snd[v];
            if (pred_len[snd] == 0) begin
              pred_act[v] = 1'b0;
            end else begin
              if (pred_pos[v] < pred_len[snd]) begin
                a = pred_base[snd] + pred_pos[v][15:0];
                l = sat16(l + $signed(pred_mem[a][15:0]));
                r = sat16(r + $signed(pred_mem[a][31:16]));
                pred_pos[v] = pred_pos[v] + 17'd1;
              end
              if (pred_pos[v] >= pred_len[snd]) pred_act[v] = 1'b0;
            end
          end
        end
        mix_queue.push_back('{mix_left: l[15:0], mix_right: r[15:0]});
      end
    endcase
  endfunction

  function automatic svm_in_t rand_fields();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    return noise[$bits(svm_in_t)-1:0];
  endfunction

  function automatic void push_cmd(logic [1:0] f, int id, int rs, int addr, int sl, int sr,
                                   int base, int len);
    svm_in_t c;
    c = rand_fields();  // unused fields carry noise
    c.func = f;
    c.sound_id = id[5:0];
    c.restart = rs[0];
    c.mem_addr = addr[15:0];
    c.sample_left = sl[15:0];
    c.sample_right = sr[15:0];
    c.sound_base = base[15:0];
    c.sound_frames = len[16:0];
    cmd_queue.push_back(c);
  endfunction

  // Random descriptor that stays in the written window; rarely a long one.
  function automatic void push_rand_desc(int id);
    int len, base;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = $urandom_range(100, WIN_SIZE - 1);
      default: len = $urandom_range(1, 12);
    endcase
    base = WIN_BASE + $urandom_range(0, WIN_SIZE - 1 - len);
    push_cmd(FUNC_DESC, id, 0, 0, 0, 0, base, len);
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Driver: holds start until the transfer, then pulls the next command or idles for a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else if (start && !busy) begin
      apply_command(in_data);
      if (cmd_queue.size() > 0 && $urandom_range(0, 3) != 0) begin
        in_data <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() > 0) begin
        in_data <= cmd_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed frame is checked against the oldest prediction.
  always @(posedge clk) begin
    svm_out_t exp_mix;
    if (rst_n) begin
      if ((start && !busy) || out_valid) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid) begin
        if (mix_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected frame L=%0d R=%0d", out_data.mix_left,
                     out_data.mix_right);
        end else begin
          exp_mix = mix_queue.pop_front();
          if (out_data.mix_left !== exp_mix.mix_left ||
              out_data.mix_right !== exp_mix.mix_right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: mix L=%0d R=%0d, expected L=%0d R=%0d",
                       out_data.mix_left, out_data.mix_right,
                       exp_mix.mix_left, exp_mix.mix_right);
          end
        end
      end
    end
  end

  initial begin
    int n, id, kind;
    rst_n = 1'b0;
    stim_done = 1'b0;
    for (int s = 0; s < NUM_SOUNDS; s++) begin
      pred_base[s] = '0;
      pred_len[s] = '0;
      pred_pend[s] = 1'b0;
      pred_rst[s] = 1'b0;
    end
    for (int v = 0; v < NUM_VOICES; v++) begin
      pred_act[v] = 1'b0;
      pred_snd[v] = '0;
      pred_pos[v] = '0;
    end

    // Fill the playable window; it wraps through address 0 via modulo depth.
    for (int i = 0; i < WIN_SIZE; i++)
      push_cmd(FUNC_SAMPLE, $urandom, $urandom, (WIN_BASE + i) % MEM_DEPTH,
               rand_sample(), rand_sample(), $urandom, $urandom);
    // Full-scale frames for saturation at both rails.
    push_cmd(FUNC_SAMPLE, 0, 0, WIN_BASE, 32767, -32768, 0, 0);
    push_cmd(FUNC_SAMPLE, 0, 0, WIN_BASE + 1, -32768, 32767, 0, 0);

    // Directed part.
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);                  // silent tick
    push_cmd(FUNC_TRIGGER, 5, 0, 0, 0, 0, 0, 0);               // absent sound
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_DESC, 0, 0, 0, 0, 0, WIN_BASE, 2);
    push_cmd(FUNC_DESC, 63, 0, 0, 0, 0, WIN_BASE + 1, 3);
    for (int s = 1; s < 40; s++)
      push_cmd(FUNC_DESC, s, 0, 0, 0, 0, WIN_BASE, 2);
    // Many voices on the same rail frame saturate; more than 32 drop.
    for (int s = 0; s < 40; s++)
      push_cmd(FUNC_TRIGGER, s, s[0], 0, 0, 0, 0, 0);
    push_cmd(FUNC_TRIGGER, 63, 1, 0, 0, 0, 0, 0);
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
    // Second trigger in the same tick is ignored; restart an active voice.
    push_cmd(FUNC_TRIGGER, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_TRIGGER, 0, 1, 0, 0, 0, 0, 0);
    push_cmd(FUNC_TRIGGER, 1, 1, 0, 0, 0, 0, 0);
    push_cmd(FUNC_DESC, 2, 0, 0, 0, 0, WIN_BASE, 1);            // shrink in play
    push_cmd(FUNC_DESC, 3, 0, 0, 0, 0, WIN_BASE, 0);            // remove in play
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);

    // Random part: mostly triggers and ticks on short sounds.
    for (int s = 0; s < NUM_SOUNDS; s++) push_rand_desc(s);
    n = 0;
    while (n < 876) begin
      kind = $urandom_range(0, 99);
      id = $urandom_range(0, NUM_SOUNDS - 1);
      if (kind < 40) begin
        push_cmd(FUNC_TRIGGER, id, $urandom_range(0, 1), 0, 0, 0, 0, 0);
      end else if (kind < 80) begin
        push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
      end else if (kind < 90) begin
        push_rand_desc(id);
      end else begin
        push_cmd(FUNC_SAMPLE, 0, 0, WIN_BASE + $urandom_range(0, WIN_SIZE - 1),
                 rand_sample(), rand_sample(), 0, 0);
      end
      n++;
    end
    push_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0);
    stim_done = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // End of run: drained queues plus a tick's latency, or the watchdog fires.
  initial begin
    wait (stim_done && rst_n);
    while (cmd_queue.size() > 0 || start || mix_queue.size() > 0) begin
      @(posedge clk);
      if (wdog >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
    repeat (300) @(posedge clk);
    if (mismatches == 0 && mix_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
